// File: rtl/core/ftpd_pkg.sv
package ftpd_pkg;

   localparam int CMD_W   = 3;
   localparam int SLOT_W  = 4;
   localparam int POS_W   = 16;
   localparam int COUNT_W = 4;
   localparam int STAT_W  = 3;
   localparam int DIR_W   = 2;
   localparam int THR_W   = 16;

   localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MOTION = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UP     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FRAME  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RESET  = 3'd5;

   localparam logic [STAT_W-1:0] ST_IGNORE = 3'd0;
   localparam logic [STAT_W-1:0] ST_BEGIN  = 3'd1;
   localparam logic [STAT_W-1:0] ST_UPDATE = 3'd2;
   localparam logic [STAT_W-1:0] ST_FINISH = 3'd3;
   localparam logic [STAT_W-1:0] ST_CANCEL = 3'd4;

   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_IN   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_OUT  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_ZOOM_THRESHOLD = 1'b0;
   localparam logic [THR_W-1:0] ZOOM_THRESHOLD_RESET = 16'd400;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SLOT_W-1:0] slot;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DIR_W-1:0]  last_dir;
      logic [DIR_W-1:0]  total_dir;
   } result_type;

endpackage

// File: rtl/core/ftpd_ifs.sv
interface ftpd_req_if;
   logic                             valid;
   logic                             ready;
   logic [ftpd_pkg::CMD_W-1:0]       cmd;
   logic [ftpd_pkg::SLOT_W-1:0]      slot;
   logic [ftpd_pkg::POS_W-1:0]       pos_x;
   logic [ftpd_pkg::POS_W-1:0]       pos_y;

   modport source (output valid, cmd, slot, pos_x, pos_y, input ready);
   modport sink (input valid, cmd, slot, pos_x, pos_y, output ready);
endinterface

interface ftpd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ftpd_pkg::STAT_W-1:0]      status;
   logic [ftpd_pkg::DIR_W-1:0]       last_dir;
   logic [ftpd_pkg::DIR_W-1:0]       total_dir;

   modport source (output valid, status, last_dir, total_dir, input ready);
   modport sink (input valid, status, last_dir, total_dir, output ready);
endinterface

// File: rtl/core/ftpd_csr.sv
module ftpd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ftpd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ftpd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ftpd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [ftpd_pkg::THR_W-1:0]        zoom_threshold
);

   logic [ftpd_pkg::THR_W-1:0] thr_ff;
   logic [ftpd_pkg::THR_W-1:0] thr_in;
   logic                       hit;

   assign pready = 1'b1;
   assign hit    = (paddr[ftpd_pkg::CSR_ADDR_W-1:2] == ftpd_pkg::REG_ZOOM_THRESHOLD);

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && pready && hit) begin
         thr_in = pwdata[ftpd_pkg::THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ftpd_pkg::ZOOM_THRESHOLD_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign prdata = hit ? ftpd_pkg::CSR_DATA_W'(thr_ff) : '0;
   assign zoom_threshold = thr_ff;

endmodule

// File: rtl/core/ftpd_spread.sv
module ftpd_spread #(
   parameter int FINGERS    = 5,
   parameter int COORD_BITS = 16,
   parameter int SUM_W      = 19
) (
   input  logic [FINGERS-1:0][2*COORD_BITS-1:0] pts,
   output logic [SUM_W-1:0]                     sum
);

   logic [FINGERS-1:1][SUM_W-1:0] term;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      for (int i = 1; i < FINGERS; i++) begin
         term[i] = SUM_W'(abs_diff(pts[0][COORD_BITS-1:0], pts[i][COORD_BITS-1:0]))
                 + SUM_W'(abs_diff(pts[0][2*COORD_BITS-1:COORD_BITS],
                                   pts[i][2*COORD_BITS-1:COORD_BITS]));
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 1; i < FINGERS; i++) begin
         sum = sum + term[i];
      end
   end

endmodule

// File: rtl/core/ftpd_core.sv
module ftpd_core #(
   parameter int FINGERS    = 5,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          item_v,
   input  ftpd_pkg::req_item_type        item,
   input  logic [ftpd_pkg::THR_W-1:0]    zoom_threshold,
   output ftpd_pkg::result_type          res
);

   localparam int PT_W   = 2 * COORD_BITS;
   localparam int SUM_W  = COORD_BITS + $clog2(2 * (FINGERS - 1));
   localparam int LIM_W  = ftpd_pkg::THR_W + $clog2(FINGERS);
   localparam int DIFF_W = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 1;

   logic [ftpd_pkg::COUNT_W-1:0]  cnt_ff, cnt_in, cnt_up, cnt_dn;
   logic                          canc_ff, canc_in;
   logic                          started_ff, started_in;
   logic [ftpd_pkg::DIR_W-1:0]    dir_ff, dir_in;
   logic [FINGERS-1:0][PT_W-1:0]  start_ff, start_in;
   logic [FINGERS-1:0][PT_W-1:0]  last_ff, last_in;
   logic [FINGERS-1:0][PT_W-1:0]  cur_ff, cur_in;
   logic [SUM_W-1:0]              sum_start_ff, sum_start_in;
   logic [SUM_W-1:0]              sum_last_ff, sum_last_in;
   logic [SUM_W-1:0]              sum_cur_ff, sum_cur_in;
   logic [ftpd_pkg::STAT_W-1:0]   status_ff, status_in;

   logic [PT_W-1:0]               pt;
   logic                          slot_ok;
   logic [DIFF_W-1:0]             lim;
   logic [DIFF_W-1:0]             frame_d, frame_mag;
   logic [DIFF_W-1:0]             total_d, total_mag;

   assign pt      = {COORD_BITS'(item.pos_y), COORD_BITS'(item.pos_x)};
   assign slot_ok = (item.slot < ftpd_pkg::SLOT_W'(FINGERS));
   assign cnt_up  = (cnt_ff == ftpd_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   assign cnt_dn  = (cnt_ff == '0) ? cnt_ff : cnt_ff - 1'b1;
   assign lim     = DIFF_W'(zoom_threshold) * DIFF_W'(FINGERS - 1);

   assign frame_d   = DIFF_W'(sum_cur_ff) - DIFF_W'(sum_last_ff);
   assign frame_mag = frame_d[DIFF_W-1] ? -frame_d : frame_d;
   assign total_d   = DIFF_W'(sum_cur_ff) - DIFF_W'(sum_start_ff);
   assign total_mag = total_d[DIFF_W-1] ? -total_d : total_d;

   always_comb begin
      cnt_in     = cnt_ff;
      canc_in    = canc_ff;
      started_in = started_ff;
      dir_in     = dir_ff;
      start_in   = start_ff;
      last_in    = last_ff;
      cur_in     = cur_ff;
      status_in  = ftpd_pkg::ST_IGNORE;
      unique case (item.cmd)
         ftpd_pkg::CMD_DOWN: begin
            cnt_in = cnt_up;
            if (!canc_ff) begin
               if ((cnt_up <= ftpd_pkg::COUNT_W'(FINGERS)) && slot_ok) begin
                  for (int i = 0; i < FINGERS; i++) begin
                     if (item.slot == ftpd_pkg::SLOT_W'(i)) begin
                        start_in[i] = pt;
                     end
                  end
               end
               if (cnt_up == ftpd_pkg::COUNT_W'(FINGERS)) begin
                  started_in = 1'b1;
                  last_in    = start_in;
                  cur_in     = start_in;
                  status_in  = ftpd_pkg::ST_BEGIN;
               end else if (cnt_up > ftpd_pkg::COUNT_W'(FINGERS)) begin
                  canc_in   = 1'b1;
                  status_in = ftpd_pkg::ST_CANCEL;
               end
            end
         end
         ftpd_pkg::CMD_MOTION: begin
            if (!canc_ff && started_ff && slot_ok) begin
               for (int i = 0; i < FINGERS; i++) begin
                  if (item.slot == ftpd_pkg::SLOT_W'(i)) begin
                     cur_in[i] = pt;
                  end
               end
            end
         end
         ftpd_pkg::CMD_UP: begin
            cnt_in = cnt_dn;
            if (cnt_dn == '0) begin
               if (!canc_ff && started_ff && (dir_ff != ftpd_pkg::DIR_NONE)) begin
                  status_in = ftpd_pkg::ST_FINISH;
               end else begin
                  canc_in    = 1'b0;
                  started_in = 1'b0;
                  dir_in     = ftpd_pkg::DIR_NONE;
                  start_in   = '0;
                  last_in    = '0;
                  cur_in     = '0;
               end
            end
         end
         ftpd_pkg::CMD_FRAME: begin
            if (!canc_ff && started_ff && (frame_mag >= lim)) begin
               last_in   = cur_ff;
               dir_in    = (!frame_d[DIFF_W-1] && (frame_d != '0)) ?
                           ftpd_pkg::DIR_IN : ftpd_pkg::DIR_OUT;
               status_in = ftpd_pkg::ST_UPDATE;
            end
         end
         ftpd_pkg::CMD_CANCEL: begin
            canc_in   = 1'b1;
            status_in = ftpd_pkg::ST_CANCEL;
         end
         ftpd_pkg::CMD_RESET: begin
            canc_in    = 1'b0;
            started_in = 1'b0;
            dir_in     = ftpd_pkg::DIR_NONE;
            start_in   = '0;
            last_in    = '0;
            cur_in     = '0;
         end
         default: begin
         end
      endcase
   end

   ftpd_spread #(.FINGERS(FINGERS), .COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_spread_start (
      .pts (start_in),
      .sum (sum_start_in)
   );

   ftpd_spread #(.FINGERS(FINGERS), .COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_spread_last (
      .pts (last_in),
      .sum (sum_last_in)
   );

   ftpd_spread #(.FINGERS(FINGERS), .COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_spread_cur (
      .pts (cur_in),
      .sum (sum_cur_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         canc_ff      <= 1'b0;
         started_ff   <= 1'b0;
         dir_ff       <= ftpd_pkg::DIR_NONE;
         start_ff     <= '0;
         last_ff      <= '0;
         cur_ff       <= '0;
         sum_start_ff <= '0;
         sum_last_ff  <= '0;
         sum_cur_ff   <= '0;
      end else if (en && item_v) begin
         cnt_ff       <= cnt_in;
         canc_ff      <= canc_in;
         started_ff   <= started_in;
         dir_ff       <= dir_in;
         start_ff     <= start_in;
         last_ff      <= last_in;
         cur_ff       <= cur_in;
         sum_start_ff <= sum_start_in;
         sum_last_ff  <= sum_last_in;
         sum_cur_ff   <= sum_cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         status_ff <= status_in;
      end
   end

   always_comb begin
      res.status   = status_ff;
      res.last_dir = dir_ff;
      if (!total_d[DIFF_W-1] && (total_mag > lim)) begin
         res.total_dir = ftpd_pkg::DIR_IN;
      end else if (total_d[DIFF_W-1] && (total_mag > lim)) begin
         res.total_dir = ftpd_pkg::DIR_OUT;
      end else begin
         res.total_dir = ftpd_pkg::DIR_NONE;
      end
   end

   a_idle_no_dir: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (dir_ff == ftpd_pkg::DIR_NONE))
      else $error("direction set without an active gesture");

   a_idle_points_clear: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> ((sum_cur_ff == '0) && (sum_last_ff == '0)))
      else $error("tracking points nonzero without an active gesture");

endmodule

// File: rtl/core/five_touch_pinch_detector.sv
// Five-finger pinch detector. Each touch event transaction on req yields exactly one
// result transaction on rsp, in order. The block accepts one event per clock cycle
// when rsp is not stalled; a result passes through the input register, the gesture
// state register and the result register after its event is accepted. The critical path is
// the update of the stored points followed by the Manhattan spread sum over FINGERS
// points. zoom_threshold sits at byte address 0 of the APB port and resets to 400.
module five_touch_pinch_detector #(
   parameter int FINGERS    = 5,
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   ftpd_req_if.sink                          req,
   ftpd_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ftpd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ftpd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ftpd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   logic                       en;
   logic                       a_v_ff, a_v_in;
   ftpd_pkg::req_item_type     a_item_ff;
   logic                       b_v_ff, b_v_in;
   logic                       c_v_ff, c_v_in;
   ftpd_pkg::result_type       c_res_ff;
   ftpd_pkg::result_type       core_res;
   logic [ftpd_pkg::THR_W-1:0] zoom_threshold;
   logic                       req_take;

   ftpd_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .zoom_threshold (zoom_threshold)
   );

   assign en        = !c_v_ff || rsp.ready;
   assign req.ready = en || !a_v_ff;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      a_v_in = a_v_ff;
      if (req_take) begin
         a_v_in = 1'b1;
      end else if (en) begin
         a_v_in = 1'b0;
      end
      b_v_in = en ? a_v_ff : b_v_ff;
      c_v_in = en ? b_v_ff : c_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         c_v_ff <= c_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_item_ff.cmd   <= req.cmd;
         a_item_ff.slot  <= req.slot;
         a_item_ff.pos_x <= req.pos_x;
         a_item_ff.pos_y <= req.pos_y;
      end
      if (en) begin
         c_res_ff <= core_res;
      end
   end

   ftpd_core #(.FINGERS(FINGERS), .COORD_BITS(COORD_BITS)) u_core (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .item_v         (a_v_ff),
      .item           (a_item_ff),
      .zoom_threshold (zoom_threshold),
      .res            (core_res)
   );

   assign rsp.valid     = c_v_ff;
   assign rsp.status    = c_res_ff.status;
   assign rsp.last_dir  = c_res_ff.last_dir;
   assign rsp.total_dir = c_res_ff.total_dir;

   a_finish_has_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status == ftpd_pkg::ST_FINISH)) |-> (rsp.last_dir != ftpd_pkg::DIR_NONE))
      else $error("finished gesture reported with no direction");

   a_update_has_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status == ftpd_pkg::ST_UPDATE)) |-> (rsp.last_dir != ftpd_pkg::DIR_NONE))
      else $error("update reported with no direction");

   a_begin_no_total: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status == ftpd_pkg::ST_BEGIN)) |-> (rsp.total_dir == ftpd_pkg::DIR_NONE))
      else $error("gesture begun with nonzero total direction");

endmodule

// File: test/five_touch_pinch_detector_tb.sv
`timescale 1ns / 100ps

module five_touch_pinch_detector_tb;

   localparam int NUM_FINGERS = 5;
   localparam int COORD_MAX = 65535;
   localparam int SCRIPT_LEN = 23;
   localparam logic [ftpd_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [ftpd_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam logic [ftpd_pkg::CSR_ADDR_W-1:0] THRESHOLD_ADDR =
      {ftpd_pkg::REG_ZOOM_THRESHOLD, 2'b00};
   localparam logic [ftpd_pkg::POS_W-1:0] POS_TOP = 16'hFFFF;

   typedef struct packed {
      logic [ftpd_pkg::POS_W-1:0] x;
      logic [ftpd_pkg::POS_W-1:0] y;
   } point_type;

   typedef struct {
      ftpd_pkg::req_item_type event_item;
      bit                     typed;
      ftpd_pkg::result_type   want;
   } script_row_type;

   localparam ftpd_pkg::result_type QUIET =
      '{ftpd_pkg::ST_IGNORE, ftpd_pkg::DIR_NONE, ftpd_pkg::DIR_NONE};

   logic                            clock;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [ftpd_pkg::CSR_ADDR_W-1:0] paddr;
   logic [ftpd_pkg::CSR_DATA_W-1:0] pwdata;
   logic [ftpd_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   ftpd_req_if req_if ();
   ftpd_rsp_if rsp_if ();

   bit steady_flow;
   bit hold_req;
   int error_count;
   int items_sent;
   int results_checked;
   int settings_used;
   int status_tally [5];
   ftpd_pkg::result_type reports_due [$];
   script_row_type script [SCRIPT_LEN];

   logic [ftpd_pkg::THR_W-1:0]   threshold_model;
   logic [ftpd_pkg::COUNT_W-1:0] fingers_down;
   bit                           gesture_cancelled;
   bit                           gesture_started;
   logic [ftpd_pkg::DIR_W-1:0]   zoom_dir;
   point_type                    start_pts [NUM_FINGERS];
   point_type                    last_pts [NUM_FINGERS];
   point_type                    live_pts [NUM_FINGERS];

   five_touch_pinch_detector u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic longint coord_gap(input logic [ftpd_pkg::POS_W-1:0] a,
                                        input logic [ftpd_pkg::POS_W-1:0] b);
      return (a > b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
   endfunction

   function automatic longint spread_of(input point_type pts [NUM_FINGERS]);
      longint sum;
      sum = 0;
      for (int i = 1; i < NUM_FINGERS; i++)
         sum += coord_gap(pts[0].x, pts[i].x) + coord_gap(pts[0].y, pts[i].y);
      return sum;
   endfunction

   function automatic void clear_touch_state();
      gesture_cancelled = 1'b0;
      gesture_started = 1'b0;
      zoom_dir = ftpd_pkg::DIR_NONE;
      foreach (start_pts[i]) begin
         start_pts[i] = '0;
         last_pts[i] = '0;
         live_pts[i] = '0;
      end
   endfunction

   function automatic ftpd_pkg::result_type advance_gesture(input ftpd_pkg::req_item_type ev);
      ftpd_pkg::result_type res;
      point_type  pt;
      longint     limit;
      longint     delta;
      longint     span;
      bit         slot_ok;
      pt = '{ev.pos_x, ev.pos_y};
      slot_ok = ev.slot < NUM_FINGERS;
      limit = (NUM_FINGERS - 1) * longint'(threshold_model);
      res.status = ftpd_pkg::ST_IGNORE;
      case (ev.cmd)
         ftpd_pkg::CMD_DOWN: begin
            if (fingers_down != ftpd_pkg::COUNT_MAX) fingers_down++;
            if (!gesture_cancelled) begin
               if (fingers_down <= NUM_FINGERS && slot_ok) start_pts[ev.slot] = pt;
               if (fingers_down == NUM_FINGERS) begin
                  gesture_started = 1'b1;
                  last_pts = start_pts;
                  live_pts = start_pts;
                  res.status = ftpd_pkg::ST_BEGIN;
               end else if (fingers_down > NUM_FINGERS) begin
                  gesture_cancelled = 1'b1;
                  res.status = ftpd_pkg::ST_CANCEL;
               end
            end
         end
         ftpd_pkg::CMD_MOTION: begin
            if (!gesture_cancelled && gesture_started && slot_ok) live_pts[ev.slot] = pt;
         end
         ftpd_pkg::CMD_UP: begin
            if (fingers_down != 0) fingers_down--;
            if (fingers_down == 0) begin
               if (!gesture_cancelled && gesture_started && zoom_dir != ftpd_pkg::DIR_NONE)
                  res.status = ftpd_pkg::ST_FINISH;
               else
                  clear_touch_state();
            end
         end
         ftpd_pkg::CMD_FRAME: begin
            if (!gesture_cancelled && gesture_started) begin
               delta = spread_of(live_pts) - spread_of(last_pts);
               span = (delta < 0) ? -delta : delta;
               if (span >= limit) begin
                  last_pts = live_pts;
                  zoom_dir = (delta > 0) ? ftpd_pkg::DIR_IN : ftpd_pkg::DIR_OUT;
                  res.status = ftpd_pkg::ST_UPDATE;
               end
            end
         end
         ftpd_pkg::CMD_CANCEL: begin
            gesture_cancelled = 1'b1;
            res.status = ftpd_pkg::ST_CANCEL;
         end
         ftpd_pkg::CMD_RESET: clear_touch_state();
         default: ;
      endcase
      delta = spread_of(live_pts) - spread_of(start_pts);
      res.last_dir = zoom_dir;
      res.total_dir = (delta > limit) ? ftpd_pkg::DIR_IN :
                      (delta < -limit) ? ftpd_pkg::DIR_OUT : ftpd_pkg::DIR_NONE;
      return res;
   endfunction

   task automatic push_event(input ftpd_pkg::req_item_type ev, input bit typed,
                             input ftpd_pkg::result_type want);
      ftpd_pkg::result_type predicted;
      while (!steady_flow && $urandom_range(99) < 19) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= ev.cmd;
      req_if.slot <= ev.slot;
      req_if.pos_x <= ev.pos_x;
      req_if.pos_y <= ev.pos_y;
      do @(posedge clock); while (!req_if.ready);
      predicted = advance_gesture(ev);
      status_tally[predicted.status]++;
      reports_due.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic send(input int cmd, input int slot, input int x, input int y);
      ftpd_pkg::req_item_type ev;
      ev = '{ftpd_pkg::CMD_W'(cmd), ftpd_pkg::SLOT_W'(slot), ftpd_pkg::POS_W'(x),
             ftpd_pkg::POS_W'(y)};
      push_event(ev, 1'b0, QUIET);
   endtask

   function automatic int finger_x(input int slot, input int cx, input int spread);
      if (slot == 0) return cx;
      return (slot == 1 || slot == 3) ? cx + spread : cx - spread;
   endfunction

   function automatic int finger_y(input int slot, input int cy, input int spread);
      if (slot == 0) return cy;
      return (slot == 1 || slot == 2) ? cy + spread : cy - spread;
   endfunction

   task automatic run_pinch();
      int cx;
      int cy;
      int spread;
      int turn;
      int steps;
      int s;
      while (fingers_down != 0)
         send(ftpd_pkg::CMD_UP, $urandom_range(15), $urandom_range(COORD_MAX),
              $urandom_range(COORD_MAX));
      if ($urandom_range(7) == 0) send(ftpd_pkg::CMD_RESET, 0, 0, 0);
      cx = $urandom_range(32267, 33267);
      cy = $urandom_range(32267, 33267);
      spread = $urandom_range(32000);
      turn = $urandom_range(NUM_FINGERS - 1);
      for (int i = 0; i < NUM_FINGERS; i++) begin
         s = (i + turn) % NUM_FINGERS;
         send(ftpd_pkg::CMD_DOWN, s, finger_x(s, cx, spread), finger_y(s, cy, spread));
      end
      steps = $urandom_range(2, 12);
      repeat (steps) begin
         if ($urandom_range(3) == 0) begin
            for (int f = 0; f < NUM_FINGERS; f++)
               send(ftpd_pkg::CMD_MOTION, f, $urandom_range(COORD_MAX),
                    $urandom_range(COORD_MAX));
         end else begin
            if ($urandom_range(4) == 0)
               spread = $urandom_range(32000);
            else
               spread = spread + int'($urandom_range(1200)) - 600;
            if (spread < 0) spread = 0;
            if (spread > 32000) spread = 32000;
            for (int f = 1; f < NUM_FINGERS; f++)
               send(ftpd_pkg::CMD_MOTION, f, finger_x(f, cx, spread), finger_y(f, cy, spread));
         end
         if ($urandom_range(5) == 0)
            send(ftpd_pkg::CMD_MOTION, $urandom_range(5, 15), $urandom_range(COORD_MAX), 0);
         send(ftpd_pkg::CMD_FRAME, $urandom_range(15), $urandom_range(COORD_MAX),
              $urandom_range(COORD_MAX));
         if ($urandom_range(29) == 0)
            send(ftpd_pkg::CMD_CANCEL, $urandom_range(15), 0, 0);
         else if ($urandom_range(29) == 0)
            send(ftpd_pkg::CMD_DOWN, $urandom_range(15), $urandom_range(COORD_MAX), 0);
      end
      repeat (NUM_FINGERS)
         send(ftpd_pkg::CMD_UP, $urandom_range(15), 0, $urandom_range(COORD_MAX));
   endtask

   task automatic run_pileup();
      int n;
      n = $urandom_range(6, 18);
      repeat (n) begin
         send(ftpd_pkg::CMD_DOWN, $urandom_range(15), $urandom_range(COORD_MAX),
              $urandom_range(COORD_MAX));
         if ($urandom_range(3) == 0) send(ftpd_pkg::CMD_FRAME, 0, 0, 0);
      end
      repeat ($urandom_range(n)) send(ftpd_pkg::CMD_UP, $urandom_range(15), 0, 0);
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 8))
         send($urandom_range(7), $urandom_range(15), $urandom_range(COORD_MAX),
              $urandom_range(COORD_MAX));
   endtask

   task automatic run_mix(input int count);
      int stop_at;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70)
            run_pinch();
         else if (pick < 85)
            run_pileup();
         else
            run_noise();
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input bit write, input logic [ftpd_pkg::THR_W-1:0] value,
                             output logic [ftpd_pkg::CSR_DATA_W-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= THRESHOLD_ADDR;
      pwdata <= ftpd_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_threshold(input logic [ftpd_pkg::THR_W-1:0] value);
      logic [ftpd_pkg::CSR_DATA_W-1:0] readback;
      drain();
      csr_access(1'b1, value, readback);
      threshold_model = value;
      csr_access(1'b0, '0, readback);
      if (readback !== ftpd_pkg::CSR_DATA_W'(value))
         report_mismatch($sformatf("threshold reads %0d, want %0d", readback, value));
      settings_used++;
   endtask

   // hold off on request, else stall at random unless steady_flow is set
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_left = $urandom_range(200, 400);
            hold_req <= 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady_flow || $urandom_range(99) >= 19;
         end
      end
   end

   always @(posedge clock) begin
      ftpd_pkg::result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_checked++;
         if (reports_due.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want = reports_due.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_if.status, want.status));
            if (rsp_if.last_dir !== want.last_dir)
               report_mismatch($sformatf("last_dir %0d, want %0d",
                                         rsp_if.last_dir, want.last_dir));
            if (rsp_if.total_dir !== want.total_dir)
               report_mismatch($sformatf("total_dir %0d, want %0d",
                                         rsp_if.total_dir, want.total_dir));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL five_touch_pinch_detector");
      $finish;
   end

   initial begin
      logic [ftpd_pkg::CSR_DATA_W-1:0] readback;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.cmd = '0;
      req_if.slot = '0;
      req_if.pos_x = '0;
      req_if.pos_y = '0;
      threshold_model = ftpd_pkg::ZOOM_THRESHOLD_RESET;
      fingers_down = '0;
      clear_touch_state();
      script = '{
         '{'{ftpd_pkg::CMD_FRAME,  4'd0,  16'd0,    16'd0},    1'b1, QUIET},
         '{'{ftpd_pkg::CMD_MOTION, 4'd0,  POS_TOP,  POS_TOP},  1'b1, QUIET},
         '{'{ftpd_pkg::CMD_UP,     4'd0,  16'd0,    16'd0},    1'b1, QUIET},
         '{'{CMD_SPARE_LO,         4'd15, POS_TOP,  POS_TOP},  1'b1, QUIET},
         '{'{CMD_SPARE_HI,         4'd0,  16'd0,    16'd0},    1'b1, QUIET},
         '{'{ftpd_pkg::CMD_DOWN,   4'd0,  16'h8000, 16'h8000}, 1'b0, QUIET},
         '{'{ftpd_pkg::CMD_DOWN,   4'd1,  16'd0,    16'd0},    1'b0, QUIET},
         '{'{ftpd_pkg::CMD_DOWN,   4'd2,  POS_TOP,  POS_TOP},  1'b0, QUIET},
         '{'{ftpd_pkg::CMD_DOWN,   4'd3,  16'd0,    POS_TOP},  1'b0, QUIET},
         '{'{ftpd_pkg::CMD_DOWN,   4'd4,  POS_TOP,  16'd0},    1'b1,
           '{ftpd_pkg::ST_BEGIN, ftpd_pkg::DIR_NONE, ftpd_pkg::DIR_NONE}},
         '{'{ftpd_pkg::CMD_MOTION, 4'd1,  16'h7000, 16'h7000}, 1'b0, QUIET},
         '{'{ftpd_pkg::CMD_MOTION, 4'd15, 16'd0,    16'd0},    1'b0, QUIET},
         '{'{ftpd_pkg::CMD_FRAME,  4'd0,  16'd0,    16'd0},    1'b0, QUIET},
         '{'{ftpd_pkg::CMD_FRAME,  4'd0,  16'd0,    16'd0},    1'b0, QUIET},
         '{'{ftpd_pkg::CMD_MOTION, 4'd2,  16'h8100, 16'h8100}, 1'b0, QUIET},
         '{'{ftpd_pkg::CMD_DOWN,   4'd9,  16'd0,    16'd0},    1'b0, QUIET},
         '{'{ftpd_pkg::CMD_DOWN,   4'd0,  POS_TOP,  POS_TOP},  1'b0, QUIET},
         '{'{ftpd_pkg::CMD_FRAME,  4'd0,  16'd0,    16'd0},    1'b0, QUIET},
         '{'{ftpd_pkg::CMD_CANCEL, 4'd0,  16'd0,    16'd0},    1'b0, QUIET},
         '{'{ftpd_pkg::CMD_RESET,  4'd0,  16'd0,    16'd0},    1'b1, QUIET},
         '{'{ftpd_pkg::CMD_UP,     4'd0,  16'd0,    16'd0},    1'b0, QUIET},
         '{'{ftpd_pkg::CMD_CANCEL, 4'd3,  16'd0,    16'd0},    1'b1,
           '{ftpd_pkg::ST_CANCEL, ftpd_pkg::DIR_NONE, ftpd_pkg::DIR_NONE}},
         '{'{ftpd_pkg::CMD_RESET,  4'd0,  POS_TOP,  POS_TOP},  1'b1, QUIET}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, '0, readback);
      if (readback !== ftpd_pkg::CSR_DATA_W'(ftpd_pkg::ZOOM_THRESHOLD_RESET))
         report_mismatch($sformatf("threshold after reset reads %0d", readback));
      foreach (script[i]) push_event(script[i].event_item, script[i].typed, script[i].want);

      set_threshold('0);
      run_mix(120);
      set_threshold('1);
      run_mix(80);
      steady_flow = 1'b1;
      set_threshold(ftpd_pkg::THR_W'($urandom_range(1, 600)));
      run_mix(120);
      steady_flow = 1'b0;
      set_threshold(16'd200);
      hold_req <= 1'b1;
      run_mix(170);
      set_threshold(ftpd_pkg::THR_W'($urandom_range(COORD_MAX)));
      run_mix(80);
      set_threshold(ftpd_pkg::ZOOM_THRESHOLD_RESET);
      run_mix(130);

      drain();
      repeat (12) @(posedge clock);
      $display("Summary: %0d touch events over %0d threshold settings, %0d results checked",
               items_sent, settings_used + 1, results_checked);
      $display("Summary: %0d gestures begun, %0d zoom updates, %0d finished, %0d cancelled",
               status_tally[ftpd_pkg::ST_BEGIN], status_tally[ftpd_pkg::ST_UPDATE],
               status_tally[ftpd_pkg::ST_FINISH], status_tally[ftpd_pkg::ST_CANCEL]);
      if (error_count == 0)
         $display("PASS five_touch_pinch_detector");
      else
         $display("FAIL five_touch_pinch_detector");
      $finish;
   end

endmodule
